FILE: rtl/xml_tag_stream_tokenizer_defines.svh
// Assertion macros for the tokenizer checker.
`ifndef XML_TAG_STREAM_TOKENIZER_DEFINES_SVH
`define XML_TAG_STREAM_TOKENIZER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define XTT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define XTT_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/xtt_pkg.sv
package xtt_pkg;

	localparam int EntityLimit = 8;
	localparam int EntCntW = $clog2(EntityLimit + 1);

	localparam logic [2:0] EV_TEXT  = 3'd0;
	localparam logic [2:0] EV_OPEN  = 3'd1;
	localparam logic [2:0] EV_ABYTE = 3'd2;
	localparam logic [2:0] EV_AEND  = 3'd3;
	localparam logic [2:0] EV_CLOSE = 3'd4;
	localparam logic [2:0] EV_END   = 3'd5;
	localparam logic [2:0] EV_ERROR = 3'd6;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_TAG_NAME  = 4'd1;
	localparam logic [3:0] ERR_END_TAG   = 4'd2;
	localparam logic [3:0] ERR_EMPTY_TAG = 4'd3;
	localparam logic [3:0] ERR_ATTR_CHAR = 4'd4;
	localparam logic [3:0] ERR_UNK_ATTR  = 4'd5;
	localparam logic [3:0] ERR_NO_EQ     = 4'd6;
	localparam logic [3:0] ERR_NO_QUOTE  = 4'd7;
	localparam logic [3:0] ERR_FORBIDDEN = 4'd8;
	localparam logic [3:0] ERR_END_VALUE = 4'd9;
	localparam logic [3:0] ERR_NO_GT     = 4'd10;
	localparam logic [3:0] ERR_ENT_UNTERM = 4'd11;
	localparam logic [3:0] ERR_ENT_UNK   = 4'd12;

	// Byte classes produced by the front part.
	localparam logic [3:0] CL_OTHER = 4'd0;
	localparam logic [3:0] CL_LT    = 4'd1;
	localparam logic [3:0] CL_GT    = 4'd2;
	localparam logic [3:0] CL_SLASH = 4'd3;
	localparam logic [3:0] CL_EQ    = 4'd4;
	localparam logic [3:0] CL_AMP   = 4'd5;
	localparam logic [3:0] CL_SEMI  = 4'd6;
	localparam logic [3:0] CL_QUOTE = 4'd7;
	localparam logic [3:0] CL_APOS  = 4'd8;
	localparam logic [3:0] CL_SPACE = 4'd9;
	localparam logic [3:0] CL_LOWER = 4'd10;
	localparam logic [3:0] CL_EOS   = 4'd11;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [7:0] value_byte;
		logic       tag_name;
		logic       is_closing;
		logic [1:0] attribute_name;
		logic [3:0] error_code;
	} out_item_t;

	// Classified byte between front and back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [3:0] cls;
		logic       known_attr;
		logic [1:0] attr_idx;
		logic       tag_ok;
		logic       tag_v;
	} tok_t;

endpackage

FILE: rtl/xml_tag_stream_tokenizer.sv
// A result passes through the classifier register, the token queue and the parser output register.
// Throughput: one byte per cycle, set by the phase update in the parser, while no unpopped result stalls it.
// Entity bytes before ';' and tag markup besides name, value, closing quote and '>' only advance state, barring errors.
// Reset: arst_n clears all control state asynchronously; queue empty, text mode.
// Entity name bytes are written without reset; only bytes written since '&' are read.
module xml_tag_stream_tokenizer import xtt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  in_item,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);

	// Front: classify each byte into a token and register it.
	logic cls_valid, cls_ready;
	tok_t cls_tok;
	// Back: parser drains the small token queue.
	logic q_valid, q_ready;
	tok_t q_tok;

	xtt_classify u_classify (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.tok_valid(cls_valid), .tok_ready(cls_ready), .tok(cls_tok)
	);

	// Two-entry queue decouples the classifier from parser stalls.
	xtt_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(cls_valid), .wr_ready(cls_ready),
		.wr_data(cls_tok), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_tok)
	);

	// Hold the result in the output register until popped; advance otherwise.
	xtt_parser u_parser (
		.clk(clk), .arst_n(arst_n), .tok_valid(q_valid), .tok_ready(q_ready),
		.tok(q_tok), .empty(empty), .pop(pop), .out_item(out_item)
	);

endmodule

FILE: rtl/xtt_classify.sv
module xtt_classify import xtt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t in_item,
	output logic     tok_valid,
	input  logic     tok_ready,
	output tok_t     tok
);

	tok_t cls_c;
	logic valid_s1;
	tok_t tok_s1;

	always_comb begin
		cls_c = '0;
		cls_c.data_byte = in_item.data_byte;
		if (in_item.end_of_stream) cls_c.cls = CL_EOS;
		else begin
			unique case (in_item.data_byte)
				8'h3c: cls_c.cls = CL_LT;
				8'h3e: cls_c.cls = CL_GT;
				8'h2f: cls_c.cls = CL_SLASH;
				8'h3d: cls_c.cls = CL_EQ;
				8'h26: cls_c.cls = CL_AMP;
				8'h3b: cls_c.cls = CL_SEMI;
				8'h22: cls_c.cls = CL_QUOTE;
				8'h27: cls_c.cls = CL_APOS;
				8'h20: cls_c.cls = CL_SPACE;
				default: cls_c.cls = (in_item.data_byte >= 8'h61 && in_item.data_byte <= 8'h7a)
					? CL_LOWER : CL_OTHER;
			endcase
		end
		unique case (in_item.data_byte)
			8'h66: begin cls_c.known_attr = 1'b1; cls_c.attr_idx = 2'd0; end
			8'h76: begin cls_c.known_attr = 1'b1; cls_c.attr_idx = 2'd1; end
			8'h6d: begin cls_c.known_attr = 1'b1; cls_c.attr_idx = 2'd2; end
			8'h6e: begin cls_c.known_attr = 1'b1; cls_c.attr_idx = 2'd3; end
			default: ;
		endcase
		cls_c.tag_ok = (in_item.data_byte == 8'h72) || (in_item.data_byte == 8'h76);
		cls_c.tag_v  = (in_item.data_byte == 8'h76);
	end

	// Single register stage; advance when it is empty or the queue can take it.
	assign full = valid_s1 && !tok_ready;
	assign tok_valid = valid_s1;
	assign tok = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (!full) valid_s1 <= push;
	end

	always_ff @(posedge clk) begin
		if (!full && push) tok_s1 <= cls_c;
	end

endmodule

FILE: rtl/xtt_fifo.sv
module xtt_fifo import xtt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  tok_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output tok_t rd_data
);

	tok_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

FILE: rtl/xtt_parser.sv
module xtt_parser import xtt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tok_valid,
	output logic      tok_ready,
	input  tok_t      tok,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);

	localparam logic [3:0] PH_TEXT = 4'd0;
	localparam logic [3:0] PH_LT = 4'd1;
	localparam logic [3:0] PH_SLASH = 4'd2;
	localparam logic [3:0] PH_AFTER_NAME = 4'd3;
	localparam logic [3:0] PH_ATTRS = 4'd4;
	localparam logic [3:0] PH_EQ = 4'd5;
	localparam logic [3:0] PH_QUOTE = 4'd6;
	localparam logic [3:0] PH_VALUE = 4'd7;
	localparam logic [3:0] PH_DONE = 4'd8;
	localparam logic [3:0] PH_EQ_UNK = 4'd9;
	localparam logic [3:0] PH_QUOTE_UNK = 4'd10;
	localparam logic [3:0] PH_VALUE_UNK = 4'd11;

	logic [3:0] phase_q, phase_d;
	logic closing_q, closing_d, tag_q, tag_d;
	logic [1:0] attr_q, attr_d;
	logic in_ent_q, in_ent_d;
	logic [EntCntW-1:0] ent_cnt_q, ent_cnt_d;
	logic [7:0] ent_q [4];
	logic [1:0] pend_q, pend_d;
	logic err_q, err_d;
	logic [3:0] code_q, code_d;

	logic out_valid_q;
	out_item_t out_q;

	logic emit;
	logic [2:0] kind;
	logic [7:0] vbyte;
	logic take;
	logic ent_wr;
	logic [7:0] dec;
	logic dec_ok;
	logic [1:0] efeed; // 0 collect, 1 decoded, 2 unterminated, 3 unknown
	logic forbidden, eos;

	// Output register frees when popped.
	assign tok_ready = !out_valid_q || pop;
	assign take = tok_valid && tok_ready;
	assign empty = !out_valid_q;
	assign out_item = out_q;
	assign eos = tok.cls == CL_EOS;
	assign forbidden = tok.cls == CL_LT || tok.cls == CL_GT || tok.cls == CL_APOS;

	always_comb begin
		dec_ok = 1'b1;
		dec = 8'h00;
		if (ent_cnt_q == EntCntW'(3) && ent_q[0] == 8'h61 && ent_q[1] == 8'h6d
			&& ent_q[2] == 8'h70) dec = 8'h26;
		else if (ent_cnt_q == EntCntW'(2) && ent_q[0] == 8'h6c && ent_q[1] == 8'h74)
			dec = 8'h3c;
		else if (ent_cnt_q == EntCntW'(2) && ent_q[0] == 8'h67 && ent_q[1] == 8'h74)
			dec = 8'h3e;
		else if (ent_cnt_q == EntCntW'(4) && ent_q[0] == 8'h71 && ent_q[1] == 8'h75
			&& ent_q[2] == 8'h6f && ent_q[3] == 8'h74) dec = 8'h22;
		else if (ent_cnt_q == EntCntW'(4) && ent_q[0] == 8'h61 && ent_q[1] == 8'h70
			&& ent_q[2] == 8'h6f && ent_q[3] == 8'h73) dec = 8'h27;
		else dec_ok = 1'b0;
		if (tok.cls == CL_SEMI) efeed = dec_ok ? 2'd1 : 2'd3;
		else if (ent_cnt_q + 1'b1 >= EntCntW'(EntityLimit)) efeed = 2'd2;
		else efeed = 2'd0;
	end

	always_comb begin
		phase_d = phase_q;
		closing_d = closing_q;
		tag_d = tag_q;
		attr_d = attr_q;
		in_ent_d = in_ent_q;
		ent_cnt_d = ent_cnt_q;
		pend_d = pend_q;
		err_d = err_q;
		code_d = code_q;
		emit = 1'b0;
		kind = EV_TEXT;
		vbyte = 8'h00;
		ent_wr = 1'b0;
		if (err_q) begin
			emit = 1'b1; kind = EV_ERROR;
		end else if (phase_q == PH_DONE) begin
			emit = 1'b1; kind = EV_END;
		end else begin
			unique case (phase_q)
				PH_TEXT: begin
					if (eos || tok.cls == CL_LT) begin
						if (in_ent_q) begin err_d = 1'b1; code_d = ERR_ENT_UNTERM; end
						else if (eos) begin phase_d = PH_DONE; emit = 1'b1; kind = EV_END; end
						else begin closing_d = 1'b0; phase_d = PH_LT; end
					end else if (in_ent_q) begin
						if (tok.cls != CL_SEMI) begin
							ent_wr = 1'b1;
							ent_cnt_d = ent_cnt_q + 1'b1;
						end
						unique case (efeed)
							2'd0: ;
							2'd1: begin in_ent_d = 1'b0; emit = 1'b1; vbyte = dec; end
							2'd2: begin in_ent_d = 1'b0; err_d = 1'b1; code_d = ERR_ENT_UNTERM; end
							default: begin in_ent_d = 1'b0; err_d = 1'b1; code_d = ERR_ENT_UNK; end
						endcase
					end else if (tok.cls == CL_AMP) begin
						in_ent_d = 1'b1; ent_cnt_d = '0;
					end else begin
						emit = 1'b1; vbyte = tok.data_byte;
					end
				end
				PH_LT, PH_SLASH: begin
					if (eos) begin err_d = 1'b1; code_d = ERR_TAG_NAME; end
					else if (phase_q == PH_LT && tok.cls == CL_SLASH) begin
						closing_d = 1'b1; phase_d = PH_SLASH;
					end else if (!tok.tag_ok) begin err_d = 1'b1; code_d = ERR_TAG_NAME; end
					else begin
						tag_d = tok.tag_v; phase_d = PH_AFTER_NAME;
						emit = 1'b1; kind = EV_OPEN;
					end
				end
				PH_AFTER_NAME: begin
					if (tok.cls == CL_SPACE) phase_d = PH_ATTRS;
					else if (tok.cls == CL_GT) begin
						phase_d = PH_TEXT; emit = 1'b1; kind = EV_CLOSE;
					end else begin err_d = 1'b1; code_d = ERR_NO_GT; end
				end
				PH_ATTRS: begin
					if (eos) begin err_d = 1'b1; code_d = ERR_END_TAG; end
					else if (tok.cls == CL_SPACE) ;
					else if (tok.cls == CL_GT) begin
						phase_d = PH_TEXT; emit = 1'b1; kind = EV_CLOSE;
					end else if (tok.cls == CL_SLASH) begin err_d = 1'b1; code_d = ERR_EMPTY_TAG; end
					else if (tok.cls != CL_LOWER) begin err_d = 1'b1; code_d = ERR_ATTR_CHAR; end
					else if (tok.known_attr) begin attr_d = tok.attr_idx; phase_d = PH_EQ; end
					else phase_d = PH_EQ_UNK;
				end
				PH_EQ, PH_EQ_UNK: begin
					if (tok.cls != CL_EQ) begin err_d = 1'b1; code_d = ERR_NO_EQ; end
					else phase_d = (phase_q == PH_EQ) ? PH_QUOTE : PH_QUOTE_UNK;
				end
				PH_QUOTE, PH_QUOTE_UNK: begin
					if (tok.cls != CL_QUOTE) begin err_d = 1'b1; code_d = ERR_NO_QUOTE; end
					else begin
						phase_d = (phase_q == PH_QUOTE) ? PH_VALUE : PH_VALUE_UNK;
						in_ent_d = 1'b0; ent_cnt_d = '0; pend_d = 2'd0;
					end
				end
				PH_VALUE_UNK: begin
					err_d = 1'b1;
					code_d = eos ? ERR_END_VALUE : (forbidden ? ERR_FORBIDDEN : ERR_UNK_ATTR);
				end
				PH_VALUE: begin
					if (eos) begin err_d = 1'b1; code_d = ERR_END_VALUE; end
					else if (forbidden) begin err_d = 1'b1; code_d = ERR_FORBIDDEN; end
					else if (tok.cls == CL_QUOTE) begin
						if (pend_q == 2'd2) begin err_d = 1'b1; code_d = ERR_ENT_UNK; end
						else if (pend_q == 2'd1 || in_ent_q) begin
							err_d = 1'b1; code_d = ERR_ENT_UNTERM;
						end else begin phase_d = PH_ATTRS; emit = 1'b1; kind = EV_AEND; end
					end else if (pend_q != 2'd0) ;
					else if (in_ent_q) begin
						if (tok.cls != CL_SEMI) begin
							ent_wr = 1'b1;
							ent_cnt_d = ent_cnt_q + 1'b1;
						end
						unique case (efeed)
							2'd0: ;
							2'd1: begin in_ent_d = 1'b0; emit = 1'b1; kind = EV_ABYTE; vbyte = dec; end
							2'd2: begin in_ent_d = 1'b0; pend_d = 2'd1; end
							default: begin in_ent_d = 1'b0; pend_d = 2'd2; end
						endcase
					end else if (tok.cls == CL_AMP) begin
						in_ent_d = 1'b1; ent_cnt_d = '0;
					end else begin
						emit = 1'b1; kind = EV_ABYTE; vbyte = tok.data_byte;
					end
				end
				default: begin phase_d = PH_DONE; emit = 1'b1; kind = EV_END; end
			endcase
			if (err_d) begin emit = 1'b1; kind = EV_ERROR; end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			closing_q <= 1'b0;
			tag_q <= 1'b0;
			attr_q <= 2'd0;
			in_ent_q <= 1'b0;
			ent_cnt_q <= '0;
			pend_q <= 2'd0;
			err_q <= 1'b0;
			code_q <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (take && emit) || (out_valid_q && !pop);
			if (take) begin
				phase_q <= phase_d;
				closing_q <= closing_d;
				tag_q <= tag_d;
				attr_q <= attr_d;
				in_ent_q <= in_ent_d;
				ent_cnt_q <= ent_cnt_d;
				pend_q <= pend_d;
				err_q <= err_d;
				code_q <= code_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ent_wr && ent_cnt_q < EntCntW'(4)) ent_q[ent_cnt_q[1:0]] <= tok.data_byte;
		if (take && emit) begin
			out_q.event_kind <= kind;
			out_q.value_byte <= (kind == EV_TEXT || kind == EV_ABYTE) ? vbyte : 8'h00;
			out_q.tag_name <= (kind >= EV_OPEN && kind <= EV_CLOSE) ? tag_d : 1'b0;
			out_q.is_closing <= (kind >= EV_OPEN && kind <= EV_CLOSE) ? closing_d : 1'b0;
			out_q.attribute_name <= (kind == EV_ABYTE || kind == EV_AEND) ? attr_d : 2'd0;
			out_q.error_code <= (kind == EV_ERROR) ? code_d : ERR_NONE;
		end
	end

endmodule

FILE: rtl/xtt_checker.sv
`include "xml_tag_stream_tokenizer_defines.svh"

module xtt_checker import xtt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_item_t out_item
);

	`XTT_ASSERT(a_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(out_item)), "result lost")
	`XTT_ASSERT(a_err_sticky, clk, arst_n,
		(!empty && pop && out_item.event_kind == EV_ERROR) |=>
		(empty || out_item.event_kind == EV_ERROR), "error not sticky")
	`XTT_ASSERT(a_kind, clk, arst_n, !empty |-> (out_item.event_kind != 3'd7), "bad event kind")
	`XTT_ASSERT_ALWAYS(a_reset, clk, !arst_n |-> (empty && !full), "reset state")

endmodule

bind xml_tag_stream_tokenizer xtt_checker u_checker (
	.clk(clk), .arst_n(arst_n), .full(full),
	.empty(empty), .pop(pop), .out_item(out_item)
);

FILE: dv/tb_xml_tag_stream_tokenizer.sv
module tb_xml_tag_stream_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	import xtt_pkg::*;

	localparam int StallLimit = 5000;
	localparam int RandomItems = 900;

	// Parser positions, mirroring the block's grammar.
	typedef enum logic [3:0] {
		P_TEXT, P_LT, P_SLASH, P_AFTER_NAME, P_ATTRS, P_EQ, P_QUOTE, P_VALUE,
		P_DONE, P_EQ_UNK, P_QUOTE_UNK, P_VALUE_UNK
	} phase_t;

	// Outcome of feeding one byte to an open entity.
	typedef enum logic [1:0] {ENT_MORE, ENT_OK, ENT_UNTERM, ENT_UNK} ent_res_t;

	// One directed request; typed rows carry their expected event.
	typedef struct {
		logic [7:0] b;
		bit         eos;
		bit         typed;
		logic [2:0] kind;
		logic [7:0] val;
		bit         tag;
		bit         cl;
		logic [1:0] attr;
	} row_t;

	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t ev;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  in_item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t out_item;

	always #10 clk = ~clk;

	xml_tag_stream_tokenizer dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item)
	);

	stim_t     stream[$];
	out_item_t pending_events[$];
	int        sent_idx = 0;
	int        quiet_cycles = 0;
	bit        failed = 1'b0;

	// Tokenizer state kept by the predictor.
	phase_t     tk_phase = P_TEXT;
	bit         tk_closing = 1'b0;
	bit         tk_tag_v = 1'b0;
	logic [1:0] tk_attr = 2'd0;
	bit         tk_in_ent = 1'b0;
	logic [3:0] tk_ent_cnt = 4'd0;
	logic [7:0] tk_ent_name[4] = '{default: 8'h00};
	logic [1:0] tk_pend_err = 2'd0;
	bit         tk_err = 1'b0;
	logic [3:0] tk_err_code = ERR_NONE;

	function automatic out_item_t make_event(logic [2:0] kind, logic [7:0] val,
			logic [3:0] code);
		out_item_t o;
		bit is_tag;
		bit attr;
		is_tag = kind inside {EV_OPEN, EV_ABYTE, EV_AEND, EV_CLOSE};
		attr = kind inside {EV_ABYTE, EV_AEND};
		o.event_kind = kind;
		o.value_byte = (kind == EV_TEXT || kind == EV_ABYTE) ? val : 8'h00;
		o.tag_name = is_tag ? tk_tag_v : 1'b0;
		o.is_closing = is_tag ? tk_closing : 1'b0;
		o.attribute_name = attr ? tk_attr : 2'd0;
		o.error_code = (kind == EV_ERROR) ? code : ERR_NONE;
		return o;
	endfunction

	function automatic out_item_t latch_error(logic [3:0] code);
		tk_err = 1'b1;
		tk_err_code = code;
		return make_event(EV_ERROR, 8'h00, code);
	endfunction

	function automatic ent_res_t entity_step(logic [7:0] b, output logic [7:0] dec);
		logic [7:0] n0, n1, n2, n3;
		n0 = tk_ent_name[0];
		n1 = tk_ent_name[1];
		n2 = tk_ent_name[2];
		n3 = tk_ent_name[3];
		dec = 8'h00;
		if (b == ";") begin
			tk_in_ent = 1'b0;
			if (tk_ent_cnt == 3 && n0 == "a" && n1 == "m" && n2 == "p") dec = "&";
			else if (tk_ent_cnt == 2 && n0 == "l" && n1 == "t") dec = "<";
			else if (tk_ent_cnt == 2 && n0 == "g" && n1 == "t") dec = ">";
			else if (tk_ent_cnt == 4 && n0 == "q" && n1 == "u" && n2 == "o" && n3 == "t")
				dec = "\"";
			else if (tk_ent_cnt == 4 && n0 == "a" && n1 == "p" && n2 == "o" && n3 == "s")
				dec = "'";
			else return ENT_UNK;
			return ENT_OK;
		end
		if (tk_ent_cnt < 4) tk_ent_name[tk_ent_cnt[1:0]] = b;
		tk_ent_cnt++;
		if (tk_ent_cnt >= EntityLimit) begin
			tk_in_ent = 1'b0;
			return ENT_UNTERM;
		end
		return ENT_MORE;
	endfunction

	// Advance the tokenizer by one request; has_ev tells whether an event results.
	function automatic void tokenize_step(in_item_t req, output bit has_ev,
			output out_item_t ev);
		logic [7:0] b;
		bit eos;
		bit forbidden;
		logic [7:0] dec;
		ent_res_t r;
		b = req.data_byte;
		eos = req.end_of_stream;
		forbidden = (b == "<" || b == ">" || b == "'");
		has_ev = 1'b1;
		ev = '0;
		if (tk_err) begin
			ev = make_event(EV_ERROR, 8'h00, tk_err_code);
			return;
		end
		if (tk_phase == P_DONE) begin
			ev = make_event(EV_END, 8'h00, ERR_NONE);
			return;
		end
		case (tk_phase)
			P_TEXT: begin
				if (eos) begin
					if (tk_in_ent) ev = latch_error(ERR_ENT_UNTERM);
					else begin
						tk_phase = P_DONE;
						ev = make_event(EV_END, 8'h00, ERR_NONE);
					end
				end else if (b == "<") begin
					if (tk_in_ent) ev = latch_error(ERR_ENT_UNTERM);
					else begin
						tk_closing = 1'b0;
						tk_phase = P_LT;
						has_ev = 1'b0;
					end
				end else if (tk_in_ent) begin
					r = entity_step(b, dec);
					case (r)
						ENT_MORE: has_ev = 1'b0;
						ENT_UNTERM: ev = latch_error(ERR_ENT_UNTERM);
						ENT_UNK: ev = latch_error(ERR_ENT_UNK);
						default: ev = make_event(EV_TEXT, dec, ERR_NONE);
					endcase
				end else if (b == "&") begin
					tk_in_ent = 1'b1;
					tk_ent_cnt = 4'd0;
					has_ev = 1'b0;
				end else ev = make_event(EV_TEXT, b, ERR_NONE);
			end
			P_LT, P_SLASH: begin
				if (eos) ev = latch_error(ERR_TAG_NAME);
				else if (tk_phase == P_LT && b == "/") begin
					tk_closing = 1'b1;
					tk_phase = P_SLASH;
					has_ev = 1'b0;
				end else if (b != "r" && b != "v") ev = latch_error(ERR_TAG_NAME);
				else begin
					tk_tag_v = (b == "v");
					tk_phase = P_AFTER_NAME;
					ev = make_event(EV_OPEN, 8'h00, ERR_NONE);
				end
			end
			P_AFTER_NAME: begin
				if (eos) ev = latch_error(ERR_NO_GT);
				else if (b == " ") begin
					tk_phase = P_ATTRS;
					has_ev = 1'b0;
				end else if (b != ">") ev = latch_error(ERR_NO_GT);
				else begin
					tk_phase = P_TEXT;
					ev = make_event(EV_CLOSE, 8'h00, ERR_NONE);
				end
			end
			P_ATTRS: begin
				if (eos) ev = latch_error(ERR_END_TAG);
				else if (b == " ") has_ev = 1'b0;
				else if (b == ">") begin
					tk_phase = P_TEXT;
					ev = make_event(EV_CLOSE, 8'h00, ERR_NONE);
				end else if (b == "/") ev = latch_error(ERR_EMPTY_TAG);
				else if (b < "a" || b > "z") ev = latch_error(ERR_ATTR_CHAR);
				else begin
					has_ev = 1'b0;
					tk_phase = P_EQ;
					case (b)
						"f": tk_attr = 2'd0;
						"v": tk_attr = 2'd1;
						"m": tk_attr = 2'd2;
						"n": tk_attr = 2'd3;
						default: tk_phase = P_EQ_UNK;
					endcase
				end
			end
			P_EQ, P_EQ_UNK: begin
				if (eos || b != "=") ev = latch_error(ERR_NO_EQ);
				else begin
					tk_phase = (tk_phase == P_EQ) ? P_QUOTE : P_QUOTE_UNK;
					has_ev = 1'b0;
				end
			end
			P_QUOTE, P_QUOTE_UNK: begin
				if (eos || b != "\"") ev = latch_error(ERR_NO_QUOTE);
				else begin
					tk_phase = (tk_phase == P_QUOTE) ? P_VALUE : P_VALUE_UNK;
					tk_in_ent = 1'b0;
					tk_ent_cnt = 4'd0;
					tk_pend_err = 2'd0;
					has_ev = 1'b0;
				end
			end
			P_VALUE_UNK: begin
				if (eos) ev = latch_error(ERR_END_VALUE);
				else if (forbidden) ev = latch_error(ERR_FORBIDDEN);
				else ev = latch_error(ERR_UNK_ATTR);
			end
			P_VALUE: begin
				if (eos) ev = latch_error(ERR_END_VALUE);
				else if (forbidden) ev = latch_error(ERR_FORBIDDEN);
				else if (b == "\"") begin
					if (tk_pend_err == 2'd1) ev = latch_error(ERR_ENT_UNTERM);
					else if (tk_pend_err == 2'd2) ev = latch_error(ERR_ENT_UNK);
					else if (tk_in_ent) ev = latch_error(ERR_ENT_UNTERM);
					else begin
						tk_phase = P_ATTRS;
						ev = make_event(EV_AEND, 8'h00, ERR_NONE);
					end
				end else if (tk_pend_err != 2'd0) has_ev = 1'b0;
				else if (tk_in_ent) begin
					r = entity_step(b, dec);
					has_ev = 1'b0;
					case (r)
						ENT_UNTERM: tk_pend_err = 2'd1;
						ENT_UNK: tk_pend_err = 2'd2;
						ENT_OK: begin
							has_ev = 1'b1;
							ev = make_event(EV_ABYTE, dec, ERR_NONE);
						end
						default: ;
					endcase
				end else if (b == "&") begin
					tk_in_ent = 1'b1;
					tk_ent_cnt = 4'd0;
					has_ev = 1'b0;
				end else ev = make_event(EV_ABYTE, b, ERR_NONE);
			end
			default: begin
				tk_phase = P_DONE;
				ev = make_event(EV_END, 8'h00, ERR_NONE);
			end
		endcase
	endfunction

	// Stream building: append raw bytes, valid entities and whole tags.
	function automatic void add_byte(logic [7:0] b, bit eos = 1'b0);
		stim_t s;
		s.req.data_byte = b;
		s.req.end_of_stream = eos;
		s.typed = 1'b0;
		s.ev = '0;
		stream.push_back(s);
	endfunction

	function automatic void add_text(string t);
		for (int i = 0; i < t.len(); i++) add_byte(t[i]);
	endfunction

	function automatic void add_entity();
		case ($urandom_range(0, 4))
			0: add_text("&amp;");
			1: add_text("&lt;");
			2: add_text("&gt;");
			3: add_text("&quot;");
			default: add_text("&apos;");
		endcase
	endfunction

	function automatic void add_tag();
		string letters;
		logic [7:0] b;
		int n_attr;
		letters = "fvmn";
		add_byte("<");
		if ($urandom_range(0, 9) < 3) add_byte("/");
		add_byte($urandom_range(0, 1) ? "v" : "r");
		if ($urandom_range(0, 3) == 0) begin
			add_byte(">");
			return;
		end
		add_byte(" ");
		n_attr = $urandom_range(0, 3);
		for (int a = 0; a < n_attr; a++) begin
			repeat ($urandom_range(0, 1)) add_byte(" ");
			add_byte(letters[$urandom_range(0, 3)]);
			add_text("=\"");
			repeat ($urandom_range(0, 6)) begin
				if ($urandom_range(0, 4) == 0) add_entity();
				else begin
					// Plain value byte: anything but forbidden, quote or ampersand.
					do b = $urandom_range(0, 255);
					while (b inside {"<", ">", "'", "\"", "&"});
					add_byte(b);
				end
			end
			add_byte("\"");
		end
		repeat ($urandom_range(0, 1)) add_byte(" ");
		add_byte(">");
	endfunction

	function automatic void add_tail();
		// Close the stream with one sticky outcome, then keep feeding it.
		case ($urandom_range(0, 7))
			0: add_byte(8'h00, 1'b1);
			1: add_text("<x");
			2: add_text("&zz;");
			3: add_text("<r /");
			4: add_text("<v q=\"a\"");
			5: add_text("<r f=\"&abcdefghij\"");
			6: add_text("<r n=\"&bogus;a\"");
			default: add_text("<v m=\"a>");
		endcase
		repeat (4) add_byte($urandom_range(0, 255), 1'b1);
	endfunction

	// Directed opening: byte extremes, text and value entities, every event type but end and error.
	row_t dir_rows[] = '{
		'{8'h00, 0, 1, EV_TEXT,  8'h00, 0, 0, 2'd0},
		'{8'hFF, 0, 1, EV_TEXT,  8'hFF, 0, 0, 2'd0},
		'{"&",   0, 0, 0, 0, 0, 0, 0},
		'{"l",   0, 0, 0, 0, 0, 0, 0},
		'{"t",   0, 0, 0, 0, 0, 0, 0},
		'{";",   0, 1, EV_TEXT,  "<",   0, 0, 2'd0},
		'{"<",   0, 0, 0, 0, 0, 0, 0},
		'{"r",   0, 1, EV_OPEN,  8'h00, 0, 0, 2'd0},
		'{">",   0, 1, EV_CLOSE, 8'h00, 0, 0, 2'd0},
		'{"<",   0, 0, 0, 0, 0, 0, 0},
		'{"/",   0, 0, 0, 0, 0, 0, 0},
		'{"v",   0, 1, EV_OPEN,  8'h00, 1, 1, 2'd0},
		'{" ",   0, 0, 0, 0, 0, 0, 0},
		'{"n",   0, 0, 0, 0, 0, 0, 0},
		'{"=",   0, 0, 0, 0, 0, 0, 0},
		'{"\"",  0, 0, 0, 0, 0, 0, 0},
		'{"x",   0, 1, EV_ABYTE, "x",   1, 1, 2'd3},
		'{"&",   0, 0, 0, 0, 0, 0, 0},
		'{"g",   0, 0, 0, 0, 0, 0, 0},
		'{"t",   0, 0, 0, 0, 0, 0, 0},
		'{";",   0, 0, 0, 0, 0, 0, 0},
		'{"\"",  0, 1, EV_AEND,  8'h00, 1, 1, 2'd3},
		'{"f",   0, 0, 0, 0, 0, 0, 0},
		'{"=",   0, 0, 0, 0, 0, 0, 0},
		'{"\"",  0, 0, 0, 0, 0, 0, 0},
		'{"\"",  0, 1, EV_AEND,  8'h00, 1, 1, 2'd0},
		'{">",   0, 1, EV_CLOSE, 8'h00, 1, 1, 2'd0}
	};

	// Idle odds per quarter of the run: none, sender, receiver, both.
	function automatic int run_quarter();
		return (stream.size() == 0) ? 0 : (sent_idx * 4) / stream.size();
	endfunction

	// Drive at the falling edge; each signal gets at most one update per edge.
	always @(negedge clk) begin
		int q;
		int tx_idle;
		int rx_idle;
		q = run_quarter();
		tx_idle = (q == 1) ? 86 : (q == 3) ? 33 : 0;
		rx_idle = (q == 2) ? 86 : (q == 3) ? 33 : 0;
		if (arst_n && sent_idx < stream.size() && $urandom_range(0, 99) >= tx_idle) begin
			push <= 1'b1;
			in_item <= stream[sent_idx].req;
		end else begin
			push <= 1'b0;
		end
		pop <= arst_n && ($urandom_range(0, 99) >= rx_idle);
	end

	// Sample at the rising edge: predict on accepted requests, check popped events.
	always @(posedge clk) begin
		bit has_ev;
		out_item_t ev;
		out_item_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n && push && !full) begin
			tokenize_step(in_item, has_ev, ev);
			if (stream[sent_idx].typed) begin
				// Hand-written rows must agree with the predictor too.
				if (!has_ev || ev != stream[sent_idx].ev) begin
					$error("row %0d: predictor gives %p, table %p", sent_idx, ev,
						stream[sent_idx].ev);
					failed = 1'b1;
				end
				pending_events.push_back(stream[sent_idx].ev);
			end else if (has_ev) begin
				pending_events.push_back(ev);
			end
			sent_idx++;
			moved = 1'b1;
		end
		if (arst_n && pop && !empty) begin
			moved = 1'b1;
			if (pending_events.size() == 0) begin
				$error("event with nothing expected: %p", out_item);
				failed = 1'b1;
			end else begin
				want = pending_events.pop_front();
				if (out_item.event_kind != want.event_kind) begin
					$error("event_kind: expected %0d, got %0d", want.event_kind,
						out_item.event_kind);
					failed = 1'b1;
				end
				if (out_item.value_byte != want.value_byte) begin
					$error("value_byte: expected %0h, got %0h", want.value_byte,
						out_item.value_byte);
					failed = 1'b1;
				end
				if (out_item.tag_name != want.tag_name) begin
					$error("tag_name: expected %0d, got %0d", want.tag_name,
						out_item.tag_name);
					failed = 1'b1;
				end
				if (out_item.is_closing != want.is_closing) begin
					$error("is_closing: expected %0d, got %0d", want.is_closing,
						out_item.is_closing);
					failed = 1'b1;
				end
				if (out_item.attribute_name != want.attribute_name) begin
					$error("attribute_name: expected %0d, got %0d", want.attribute_name,
						out_item.attribute_name);
					failed = 1'b1;
				end
				if (out_item.error_code != want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						out_item.error_code);
					failed = 1'b1;
				end
			end
		end
		// Watchdog: stop a run in which nothing moves for too long.
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("tb_xml_tag_stream_tokenizer: FAIL");
			$finish;
		end
	end

	initial begin
		stim_t s;
		int pick;
		foreach (dir_rows[i]) begin
			s.req.data_byte = dir_rows[i].b;
			s.req.end_of_stream = dir_rows[i].eos;
			s.typed = dir_rows[i].typed;
			s.ev.event_kind = dir_rows[i].kind;
			s.ev.value_byte = dir_rows[i].val;
			s.ev.tag_name = dir_rows[i].tag;
			s.ev.is_closing = dir_rows[i].cl;
			s.ev.attribute_name = dir_rows[i].attr;
			s.ev.error_code = ERR_NONE;
			stream.push_back(s);
		end
		// Well-formed stream with random content; errors and end are sticky,
		// so they only close the run.
		while (stream.size() < dir_rows.size() + RandomItems) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) add_byte($urandom_range(0, 1) ? 8'h3E : 8'h00 | (8'h80 ^
				8'($urandom_range(0, 127))));
			else if (pick < 5) add_entity();
			else add_tag();
		end
		add_tail();

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (sent_idx == stream.size());
		wait (pending_events.size() == 0);
		// Hold off for stray events past the pipeline latency.
		repeat (20) @(posedge clk);
		if (!failed && pending_events.size() == 0)
			$display("tb_xml_tag_stream_tokenizer: PASS");
		else
			$display("tb_xml_tag_stream_tokenizer: FAIL");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/xtt_pkg.sv
rtl/xtt_classify.sv
rtl/xtt_fifo.sv
rtl/xtt_parser.sv
rtl/xml_tag_stream_tokenizer.sv
rtl/xtt_checker.sv
dv/tb_xml_tag_stream_tokenizer.sv
